>>> src/owbm_pkg.sv
// Package with shared types, codes and timing constants of the one-wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int BUFFER_BYTES_DEF = 12;

    // Slot and pulse timing in microseconds.
    localparam logic [8:0] T_RESET_US      = 9'd489;
    localparam logic [8:0] T_PRESENCE_US   = 9'd90;
    localparam logic [8:0] T_CLEAR_US      = 9'd399;
    localparam logic [8:0] T_READ_SAMPLE_US = 9'd5;
    localparam logic [8:0] T_SLOT_LOW_US   = 9'd60;
    localparam logic [8:0] T_SLOT_US       = 9'd80;
    localparam logic [8:0] T_SLOT_TAIL_US  = 9'd20;

    localparam logic [1:0] SEARCH_BITS_BOTH = 2'h3;

    typedef enum logic [2:0] {
        ACT_TIMER  = 3'd0,
        ACT_RESET  = 3'd1,
        ACT_READ   = 3'd2,
        ACT_WRITE  = 3'd3,
        ACT_SEARCH = 3'd4,
        ACT_STORE  = 3'd5,
        ACT_FETCH  = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_RST    = 3'd1,
        PH_PRES   = 3'd2,
        PH_CLR    = 3'd3,
        PH_READ   = 3'd4,
        PH_WRITE  = 3'd5,
        PH_SEARCH = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        BP_OK      = 2'd0,
        BP_ERR     = 2'd1,
        BP_SAMPLE  = 2'd2,
        BP_SLOTEND = 2'd3
    } bit_phase_t;

    typedef enum logic [1:0] {
        PW_NONE = 2'd0,
        PW_REQ  = 2'd1,
        PW_KEEP = 2'd2
    } power_t;

    typedef enum logic [1:0] {
        DRIVE_REL  = 2'd0,
        DRIVE_LOW  = 2'd1,
        DRIVE_HIGH = 2'd2
    } drive_t;

    typedef enum logic [3:0] {
        R_BUSY   = 4'd0,
        R_ERROR  = 4'd1,
        R_BUSF0  = 4'd2,
        R_BUSF1  = 4'd3,
        R_BUSF3  = 4'd4,
        R_NOPRES = 4'd5,
        R_PRESOK = 4'd6,
        R_RDFAIL = 4'd7,
        R_WRFAIL = 4'd8,
        R_RDOK   = 4'd9,
        R_WROK   = 4'd10,
        R_S00    = 4'd11,
        R_S0     = 4'd12,
        R_S1     = 4'd13,
        R_S11    = 4'd14
    } resp_t;

    typedef struct packed {
        logic [2:0] action;
        logic       bus_low;
        logic [6:0] bit_count;
        logic       strong_power;
        logic       search_direction;
        logic [3:0] byte_index;
        logic [7:0] byte_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0] bus_drive;
        logic [8:0] timeout_us;
        logic [3:0] response;
        logic [7:0] read_byte;
        logic       last;
    } rsp_t;

    // Results of one request: the pull-low item comes first when dual is set.
    typedef struct packed {
        logic dual;
        rsp_t first;
        rsp_t second;
    } step_out_t;

endpackage

>>> src/owbm_if.sv
// Handshake channels for requests and results of the one-wire bus master.
`timescale 1ns / 1ps

interface owbm_cmd_if;
    logic             valid;
    logic             ready;
    owbm_pkg::cmd_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface owbm_rsp_if;
    logic             valid;
    logic             ready;
    owbm_pkg::rsp_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/owbm_core.sv
// Sequencer state, bit buffer and single-pass step logic of the one-wire bus master.
`timescale 1ns / 1ps

module owbm_core #(
    parameter int BUFFER_BYTES = owbm_pkg::BUFFER_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  owbm_pkg::cmd_t        item,
    output owbm_pkg::step_out_t   result
);

    localparam int BYTE_W   = $clog2(BUFFER_BYTES);
    localparam int ADDR_W   = (BYTE_W > 4) ? BYTE_W : 4;
    localparam int MAX_BITS = 8 * BUFFER_BYTES;

    owbm_pkg::phase_t     phase_reg, phase_next;
    owbm_pkg::bit_phase_t bitph_reg, bitph_next;
    owbm_pkg::power_t     power_reg, power_next;
    owbm_pkg::drive_t     drive_reg, drive_next;
    owbm_pkg::resp_t      resp_reg, resp_next;
    logic [6:0]           bit_index_reg, bit_index_next;
    logic [6:0]           bits_total_reg, bits_total_next;
    logic [7:0]           buf_reg [BUFFER_BYTES];

    owbm_pkg::action_t    action;
    logic [6:0]           bi_inc;
    logic [7:0]           bi_inc_wide;
    logic [6:0]           clamped;
    logic [ADDR_W-1:0]    rd_addr;
    logic [2:0]           rd_bit;
    logic [7:0]           rd_byte;
    logic                 rd_bitval;
    logic [7:0]           put_byte;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [7:0]           wr_data;
    logic [8:0]           tmo;
    logic [7:0]           rb;
    logic                 dual;
    logic                 dir;
    logic [1:0]           sbits;

    assign action      = owbm_pkg::action_t'(item.action);
    assign bi_inc      = bit_index_reg + 7'd1;
    assign bi_inc_wide = {1'b0, bi_inc} + 8'd1;
    assign clamped     = (32'(item.bit_count) > MAX_BITS) ? 7'(MAX_BITS) : item.bit_count;
    assign sbits       = buf_reg[0][1:0];

    // One buffer read per request: the byte under the bit being sampled or sent,
    // or the byte addressed by a fetch.
    always_comb
    begin
        rd_addr = ADDR_W'(bit_index_reg[6:3]);
        rd_bit  = bit_index_reg[2:0];
        if (action == owbm_pkg::ACT_FETCH)
        begin
            rd_addr = ADDR_W'(item.byte_index);
            rd_bit  = 3'd0;
        end
        else if (action == owbm_pkg::ACT_WRITE)
        begin
            rd_addr = '0;
            rd_bit  = 3'd0;
        end
        else if (action == owbm_pkg::ACT_TIMER && phase_reg == owbm_pkg::PH_WRITE)
        begin
            rd_addr = ADDR_W'(bi_inc[6:3]);
            rd_bit  = bi_inc[2:0];
        end
        rd_byte = (32'(rd_addr) < 32'(BUFFER_BYTES)) ? buf_reg[rd_addr[BYTE_W-1:0]] : 8'd0;
        rd_bitval = rd_byte[rd_bit];
        put_byte = rd_byte;
        put_byte[rd_bit] = ~item.bus_low;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bitph_next      = bitph_reg;
        power_next      = power_reg;
        drive_next      = drive_reg;
        resp_next       = resp_reg;
        bit_index_next  = bit_index_reg;
        bits_total_next = bits_total_reg;
        tmo             = 9'd0;
        rb              = 8'd0;
        dual            = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = rd_addr;
        wr_data         = put_byte;
        dir             = 1'b0;

        case (action)
            owbm_pkg::ACT_TIMER:
            begin
                case (phase_reg)
                    owbm_pkg::PH_RST:
                    begin
                        drive_next = owbm_pkg::DRIVE_REL;
                        if (!item.bus_low)
                        begin
                            resp_next  = owbm_pkg::R_BUSF1;
                            phase_next = owbm_pkg::PH_IDLE;
                        end
                        else
                        begin
                            tmo        = owbm_pkg::T_PRESENCE_US;
                            phase_next = owbm_pkg::PH_PRES;
                        end
                    end
                    owbm_pkg::PH_PRES:
                    begin
                        if (item.bus_low)
                        begin
                            phase_next = owbm_pkg::PH_CLR;
                            tmo        = owbm_pkg::T_CLEAR_US;
                        end
                        else
                        begin
                            resp_next  = owbm_pkg::R_NOPRES;
                            phase_next = owbm_pkg::PH_IDLE;
                        end
                    end
                    owbm_pkg::PH_CLR:
                    begin
                        resp_next  = item.bus_low ? owbm_pkg::R_BUSF3 : owbm_pkg::R_PRESOK;
                        phase_next = owbm_pkg::PH_IDLE;
                    end
                    owbm_pkg::PH_READ:
                    begin
                        if (bitph_reg == owbm_pkg::BP_SAMPLE)
                        begin
                            wr_en      = 1'b1;
                            bitph_next = owbm_pkg::BP_SLOTEND;
                            tmo        = owbm_pkg::T_SLOT_LOW_US;
                        end
                        else if (bitph_reg == owbm_pkg::BP_SLOTEND)
                        begin
                            bit_index_next = bi_inc;
                            if (bi_inc >= bits_total_reg)
                            begin
                                bitph_next = owbm_pkg::BP_OK;
                                resp_next  = owbm_pkg::R_RDOK;
                                phase_next = owbm_pkg::PH_IDLE;
                            end
                            else
                            begin
                                dual       = 1'b1;
                                drive_next = owbm_pkg::DRIVE_REL;
                                tmo        = owbm_pkg::T_READ_SAMPLE_US;
                                bitph_next = owbm_pkg::BP_SAMPLE;
                            end
                        end
                        else
                        begin
                            bitph_next = owbm_pkg::BP_ERR;
                            resp_next  = owbm_pkg::R_RDFAIL;
                            drive_next = owbm_pkg::DRIVE_REL;
                            phase_next = owbm_pkg::PH_IDLE;
                        end
                    end
                    owbm_pkg::PH_WRITE:
                    begin
                        if (bitph_reg == owbm_pkg::BP_SAMPLE)
                        begin
                            tmo        = owbm_pkg::T_SLOT_TAIL_US;
                            bitph_next = owbm_pkg::BP_SLOTEND;
                            if (power_reg == owbm_pkg::PW_KEEP)
                            begin
                                drive_next = owbm_pkg::DRIVE_HIGH;
                                power_next = owbm_pkg::PW_NONE;
                            end
                            else
                            begin
                                drive_next = owbm_pkg::DRIVE_REL;
                            end
                        end
                        else if (bitph_reg == owbm_pkg::BP_SLOTEND)
                        begin
                            bit_index_next = bi_inc;
                            if (bi_inc >= bits_total_reg)
                            begin
                                bitph_next = owbm_pkg::BP_OK;
                                resp_next  = owbm_pkg::R_WROK;
                                phase_next = owbm_pkg::PH_IDLE;
                            end
                            else
                            begin
                                // The strong pull-up is armed only when the next bit is the final one.
                                if (power_reg == owbm_pkg::PW_REQ
                                    && bi_inc_wide == {1'b0, bits_total_reg})
                                begin
                                    power_next = owbm_pkg::PW_KEEP;
                                end
                                if (rd_bitval)
                                begin
                                    dual       = 1'b1;
                                    bitph_next = owbm_pkg::BP_SLOTEND;
                                    tmo        = owbm_pkg::T_SLOT_US;
                                    if (power_next == owbm_pkg::PW_KEEP)
                                    begin
                                        drive_next = owbm_pkg::DRIVE_HIGH;
                                        power_next = owbm_pkg::PW_NONE;
                                    end
                                    else
                                    begin
                                        drive_next = owbm_pkg::DRIVE_REL;
                                    end
                                end
                                else
                                begin
                                    drive_next = owbm_pkg::DRIVE_LOW;
                                    bitph_next = owbm_pkg::BP_SAMPLE;
                                    tmo        = owbm_pkg::T_SLOT_LOW_US;
                                end
                            end
                        end
                        else
                        begin
                            bitph_next = owbm_pkg::BP_ERR;
                            resp_next  = owbm_pkg::R_WRFAIL;
                            drive_next = owbm_pkg::DRIVE_REL;
                            phase_next = owbm_pkg::PH_IDLE;
                        end
                    end
                    owbm_pkg::PH_SEARCH:
                    begin
                        if (bit_index_reg < 7'd2)
                        begin
                            if (bitph_reg == owbm_pkg::BP_SAMPLE)
                            begin
                                wr_en      = 1'b1;
                                bitph_next = owbm_pkg::BP_SLOTEND;
                                tmo        = owbm_pkg::T_SLOT_LOW_US;
                            end
                            else if (bitph_reg == owbm_pkg::BP_SLOTEND)
                            begin
                                bitph_next     = owbm_pkg::BP_OK;
                                bit_index_next = bi_inc;
                                if (bi_inc == 7'd2)
                                begin
                                    if (sbits == owbm_pkg::SEARCH_BITS_BOTH)
                                    begin
                                        resp_next  = owbm_pkg::R_S11;
                                        phase_next = owbm_pkg::PH_IDLE;
                                    end
                                    else
                                    begin
                                        // Both bits zero means a discrepancy: take the
                                        // requested direction.
                                        dir     = (sbits != 2'd0) ? (sbits == 2'd1)
                                                                  : (buf_reg[1] != 8'd0);
                                        wr_en   = 1'b1;
                                        wr_addr = '0;
                                        wr_data = {buf_reg[0][7:3], dir, buf_reg[0][1:0]};
                                        if (dir)
                                        begin
                                            dual       = 1'b1;
                                            bitph_next = owbm_pkg::BP_SLOTEND;
                                            tmo        = owbm_pkg::T_SLOT_US;
                                            if (power_reg == owbm_pkg::PW_KEEP)
                                            begin
                                                drive_next = owbm_pkg::DRIVE_HIGH;
                                                power_next = owbm_pkg::PW_NONE;
                                            end
                                            else
                                            begin
                                                drive_next = owbm_pkg::DRIVE_REL;
                                            end
                                        end
                                        else
                                        begin
                                            drive_next = owbm_pkg::DRIVE_LOW;
                                            bitph_next = owbm_pkg::BP_SAMPLE;
                                            tmo        = owbm_pkg::T_SLOT_LOW_US;
                                        end
                                    end
                                end
                                else
                                begin
                                    dual       = 1'b1;
                                    drive_next = owbm_pkg::DRIVE_REL;
                                    tmo        = owbm_pkg::T_READ_SAMPLE_US;
                                    bitph_next = owbm_pkg::BP_SAMPLE;
                                end
                            end
                            else
                            begin
                                bitph_next = owbm_pkg::BP_ERR;
                                resp_next  = owbm_pkg::R_RDFAIL;
                                drive_next = owbm_pkg::DRIVE_REL;
                                phase_next = owbm_pkg::PH_IDLE;
                            end
                        end
                        else if (bit_index_reg == 7'd2)
                        begin
                            if (bitph_reg == owbm_pkg::BP_SAMPLE)
                            begin
                                tmo        = owbm_pkg::T_SLOT_TAIL_US;
                                bitph_next = owbm_pkg::BP_SLOTEND;
                                if (power_reg == owbm_pkg::PW_KEEP)
                                begin
                                    drive_next = owbm_pkg::DRIVE_HIGH;
                                    power_next = owbm_pkg::PW_NONE;
                                end
                                else
                                begin
                                    drive_next = owbm_pkg::DRIVE_REL;
                                end
                            end
                            else if (bitph_reg == owbm_pkg::BP_SLOTEND)
                            begin
                                bitph_next = owbm_pkg::BP_OK;
                                phase_next = owbm_pkg::PH_IDLE;
                                case (sbits)
                                    2'd0:    resp_next = owbm_pkg::R_S00;
                                    2'd1:    resp_next = owbm_pkg::R_S0;
                                    2'd2:    resp_next = owbm_pkg::R_S1;
                                    default: resp_next = owbm_pkg::R_S11;
                                endcase
                            end
                            else
                            begin
                                // The bus is left as it is on this error path.
                                bitph_next = owbm_pkg::BP_ERR;
                                resp_next  = owbm_pkg::R_WRFAIL;
                                phase_next = owbm_pkg::PH_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            owbm_pkg::ACT_RESET:
            begin
                if (phase_reg != owbm_pkg::PH_IDLE)
                begin
                    resp_next = owbm_pkg::R_ERROR;
                end
                else if (item.bus_low)
                begin
                    resp_next  = owbm_pkg::R_BUSF0;
                    drive_next = owbm_pkg::DRIVE_REL;
                end
                else
                begin
                    resp_next  = owbm_pkg::R_BUSY;
                    tmo        = owbm_pkg::T_RESET_US;
                    drive_next = owbm_pkg::DRIVE_LOW;
                    phase_next = owbm_pkg::PH_RST;
                end
            end
            owbm_pkg::ACT_READ, owbm_pkg::ACT_SEARCH:
            begin
                if (phase_reg != owbm_pkg::PH_IDLE)
                begin
                    resp_next = owbm_pkg::R_ERROR;
                end
                else
                begin
                    resp_next      = owbm_pkg::R_BUSY;
                    bit_index_next = 7'd0;
                    dual           = 1'b1;
                    drive_next     = owbm_pkg::DRIVE_REL;
                    tmo            = owbm_pkg::T_READ_SAMPLE_US;
                    bitph_next     = owbm_pkg::BP_SAMPLE;
                    if (action == owbm_pkg::ACT_READ)
                    begin
                        bits_total_next = clamped;
                        phase_next      = owbm_pkg::PH_READ;
                    end
                    else
                    begin
                        // Search direction is parked in buffer byte one.
                        wr_en      = 1'b1;
                        wr_addr    = ADDR_W'(1);
                        wr_data    = {7'd0, item.search_direction};
                        phase_next = owbm_pkg::PH_SEARCH;
                    end
                end
            end
            owbm_pkg::ACT_WRITE:
            begin
                if (phase_reg != owbm_pkg::PH_IDLE)
                begin
                    resp_next = owbm_pkg::R_ERROR;
                end
                else
                begin
                    resp_next       = owbm_pkg::R_BUSY;
                    bits_total_next = clamped;
                    bit_index_next  = 7'd0;
                    phase_next      = owbm_pkg::PH_WRITE;
                    power_next      = item.strong_power ? owbm_pkg::PW_REQ : owbm_pkg::PW_NONE;
                    if (rd_bitval)
                    begin
                        dual       = 1'b1;
                        drive_next = owbm_pkg::DRIVE_REL;
                        bitph_next = owbm_pkg::BP_SLOTEND;
                        tmo        = owbm_pkg::T_SLOT_US;
                    end
                    else
                    begin
                        drive_next = owbm_pkg::DRIVE_LOW;
                        bitph_next = owbm_pkg::BP_SAMPLE;
                        tmo        = owbm_pkg::T_SLOT_LOW_US;
                    end
                end
            end
            owbm_pkg::ACT_STORE:
            begin
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(item.byte_index);
                wr_data = item.byte_value;
            end
            owbm_pkg::ACT_FETCH:
            begin
                rb = rd_byte;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= owbm_pkg::PH_IDLE;
            bitph_reg      <= owbm_pkg::BP_OK;
            power_reg      <= owbm_pkg::PW_NONE;
            drive_reg      <= owbm_pkg::DRIVE_REL;
            resp_reg       <= owbm_pkg::R_BUSY;
            bit_index_reg  <= 7'd0;
            bits_total_reg <= 7'd0;
            for (int i = 0; i < BUFFER_BYTES; i++)
            begin
                buf_reg[i] <= 8'd0;
            end
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            bitph_reg      <= bitph_next;
            power_reg      <= power_next;
            drive_reg      <= drive_next;
            resp_reg       <= resp_next;
            bit_index_reg  <= bit_index_next;
            bits_total_reg <= bits_total_next;
            if (wr_en && (32'(wr_addr) < 32'(BUFFER_BYTES)))
            begin
                buf_reg[wr_addr[BYTE_W-1:0]] <= wr_data;
            end
        end
    end

    always_comb
    begin
        result.dual              = dual;
        result.first.bus_drive   = owbm_pkg::DRIVE_LOW;
        result.first.timeout_us  = 9'd0;
        result.first.response    = resp_next;
        result.first.read_byte   = 8'd0;
        result.first.last        = 1'b0;
        result.second.bus_drive  = drive_next;
        result.second.timeout_us = tmo;
        result.second.response   = resp_next;
        result.second.read_byte  = rb;
        result.second.last       = 1'b1;
    end

endmodule

>>> src/one_wire_bus_master_top.sv
// Top level of the one-wire bus master: request register, sequencer and result registers.
// An accepted request waits in the request register; the edge that steps the sequencer also
// loads its first result into the result register.
// One request per cycle while the result register is free; a request that opens a read or
// write-one slot gives two results, and the next request waits behind the second result.
// Reset clears the sequencer to idle, the bit buffer to zero and the bus drive to release.
`timescale 1ns / 1ps

module one_wire_bus_master_top #(
    parameter int BUFFER_BYTES = owbm_pkg::BUFFER_BYTES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    owbm_cmd_if.sink   cmd,
    owbm_rsp_if.source rsp
);

    logic                s1_valid_reg;
    owbm_pkg::cmd_t      s1_data_reg;
    logic                out_valid_reg;
    owbm_pkg::rsp_t      out_data_reg;
    logic                hold_valid_reg;
    owbm_pkg::rsp_t      hold_data_reg;
    logic                out_free;
    logic                advance;
    owbm_pkg::step_out_t step;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = s1_valid_reg && !hold_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    owbm_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (s1_data_reg),
        .result  (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready)
        begin
            s1_data_reg <= cmd.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (hold_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= advance;
                hold_valid_reg <= advance && step.dual;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (hold_valid_reg)
            begin
                out_data_reg <= hold_data_reg;
            end
            else if (advance)
            begin
                out_data_reg  <= step.dual ? step.first : step.second;
                hold_data_reg <= step.second;
            end
        end
    end

    // The second result of a pair never stands without the first ahead of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("second result held without a first result on the output");

    // A first result that is not the last one always has its partner held behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.last) |-> hold_valid_reg)
        else $error("first result of a pair shown without its partner");

    // A request that steps the sequencer shows a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("request processed but no result presented");

endmodule
